FILE: sv/shl_pkg.sv
// Package with the shared types and constants of the screen head locator.
package shl_pkg;

	localparam int COORD_W = 19;
	localparam int SQ_W    = 34;
	localparam int DIST_W  = 35;
	localparam int HNUM_W  = 4;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_WINDOW = 2'd1;
	localparam logic [1:0] KIND_POINT  = 2'd2;

	localparam logic [1:0] REG_HEAD_COUNT = 2'd0;
	localparam logic [1:0] REG_MULTI_HEAD = 2'd1;

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [15:0]        size_w;
		logic [15:0]        size_h;
	} req_t;

	typedef struct packed {
		logic [HNUM_W-1:0] head_number;
		logic              was_inside;
	} rsp_t;

	typedef struct packed {
		logic [1:0] addr;
		logic [3:0] value;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [15:0]        w;
		logic [15:0]        h;
	} head_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

FILE: sv/shl_stream_if.sv
// Valid/ready channel interface used for requests, results and configuration.
interface shl_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/shl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module shl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/shl_eval.sv
// Per-entry containment and distance stages with the running search result.
module shl_eval #(
	parameter int NUM_W = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               clear,
	input  logic                               valid_s1,
	input  logic [NUM_W-1:0]                   num_s1,
	input  shl_pkg::head_t                     head_s1,
	input  logic signed [shl_pkg::COORD_W-1:0] qx,
	input  logic signed [shl_pkg::COORD_W-1:0] qy,
	output logic                               busy,
	output logic                               found,
	output logic [NUM_W-1:0]                   found_num,
	output logic [NUM_W-1:0]                   best_num
);
	localparam int CW = shl_pkg::COORD_W;

	logic signed [CW-1:0] hx, hy, hw, hh, cx, cy;
	logic                 contain;

	logic                        v_s2, contain_s2;
	logic signed [CW-1:0]        dx_s2, dy_s2;
	logic [NUM_W-1:0]            num_s2;
	logic signed [2*CW-1:0]      prod_x, prod_y;

	logic                        v_s3, contain_s3;
	logic [shl_pkg::SQ_W-1:0]    sqx_s3, sqy_s3;
	logic [NUM_W-1:0]            num_s3;
	logic [shl_pkg::DIST_W-1:0]  dist_sum;

	logic                        found_q, have_best_q;
	logic [NUM_W-1:0]            found_num_q, best_num_q;
	logic [shl_pkg::DIST_W-1:0]  best_d_q;

	always_comb begin
		hx = CW'(head_s1.x);
		hy = CW'(head_s1.y);
		hw = signed'(CW'(head_s1.w));
		hh = signed'(CW'(head_s1.h));
		cx = hx + signed'(CW'(head_s1.w >> 1));
		cy = hy + signed'(CW'(head_s1.h >> 1));
		contain = (qx >= hx) && (qx < hx + hw) && (qy >= hy) && (qy < hy + hh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		contain_s2 <= contain;
		dx_s2      <= cx - qx;
		dy_s2      <= cy - qy;
		num_s2     <= num_s1;
	end

	assign prod_x = dx_s2 * dx_s2;
	assign prod_y = dy_s2 * dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		contain_s3 <= contain_s2;
		sqx_s3     <= prod_x[shl_pkg::SQ_W-1:0];
		sqy_s3     <= prod_y[shl_pkg::SQ_W-1:0];
		num_s3     <= num_s2;
	end

	assign dist_sum = {1'b0, sqx_s3} + {1'b0, sqy_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			have_best_q <= 1'b0;
			found_num_q <= '0;
			best_num_q  <= '0;
			best_d_q    <= '0;
		end else if (clear) begin
			found_q     <= 1'b0;
			have_best_q <= 1'b0;
			found_num_q <= '0;
			best_num_q  <= '0;
		end else if (v_s3) begin
			if (!found_q && contain_s3) begin
				found_q     <= 1'b1;
				found_num_q <= num_s3;
			end
			// Strict compare keeps the lower-numbered head on a tie.
			if (!have_best_q || dist_sum < best_d_q) begin
				have_best_q <= 1'b1;
				best_num_q  <= num_s3;
				best_d_q    <= dist_sum;
			end
		end
	end

	assign busy      = v_s2 | v_s3;
	assign found     = found_q;
	assign found_num = found_num_q;
	assign best_num  = best_num_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> $past(v_s2))
		else $error("stage three valid without stage two");

endmodule

FILE: sv/screen_head_locator.sv
// Top level of the screen head locator: head table, scan control and result register.
//
// Requests arrive on req: a load writes one head entry (origin, width, height)
// into the head table in the cycle of its transfer and gives no result; a
// window or point query gives exactly one result on rsp. Kind 3 is dropped.
// cfg writes head_count (index 0) and multi_head_enabled (index 1); it is
// always ready and should be used only while no query is in flight.
// A query reads one table entry per cycle from the head RAM, n entries in all,
// with n = min(head_count, MAX_HEADS) when multi-head mode is on and 0
// otherwise. One query is worked on at a time.
// The result sits in an output register: req is ready again while it waits,
// and a second result waits in the finish state until rsp takes the first.
// Reset clears the control state and both registers; table entries hold
// unknown data until loaded.
module screen_head_locator #(
	parameter int MAX_HEADS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	shl_stream_if.sink   req,
	shl_stream_if.source rsp,
	shl_stream_if.sink   cfg
);
	localparam int AW    = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
	localparam int NUM_W = $clog2(MAX_HEADS + 1);
	localparam int CW    = shl_pkg::COORD_W;

	shl_pkg::state_t      state_q, state_d;
	logic [3:0]           head_count_q;
	logic                 multi_q;
	logic [NUM_W-1:0]     n_q, n_d, rd_cnt_q;
	logic [1:0]           kind_q;
	logic signed [CW-1:0] qx_q, qy_q, qx_d, qy_d;
	logic                 v_s1_q;
	logic [NUM_W-1:0]     num_s1_q;

	logic                 req_fire, is_query, scan_done;
	logic                 ram_we, rd_issue, out_load, clear;
	shl_pkg::req_t        rq;
	shl_pkg::head_t       wr_head, rd_head;
	logic                 ev_busy, ev_found;
	logic [NUM_W-1:0]     ev_found_num, ev_best_num;
	logic                 out_valid_q;
	shl_pkg::rsp_t        out_data_q, result;

	assign rq       = req.data;
	assign req_fire = req.valid && req.ready;
	assign is_query = (rq.kind == shl_pkg::KIND_WINDOW) || (rq.kind == shl_pkg::KIND_POINT);

	always_comb begin
		if (!multi_q) begin
			n_d = '0;
		end else if (32'(head_count_q) > MAX_HEADS) begin
			n_d = NUM_W'(MAX_HEADS);
		end else begin
			n_d = NUM_W'(head_count_q);
		end
		qx_d = CW'(rq.pos_x);
		qy_d = CW'(rq.pos_y);
		if (rq.kind == shl_pkg::KIND_WINDOW) begin
			qx_d = qx_d + signed'(CW'(rq.size_w >> 1));
			qy_d = qy_d + signed'(CW'(rq.size_h >> 1));
		end
	end

	assign scan_done = (rd_cnt_q == n_q) && !v_s1_q && !ev_busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			shl_pkg::ST_IDLE: begin
				if (req_fire && is_query) begin
					state_d = shl_pkg::ST_SCAN;
				end
			end
			shl_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = shl_pkg::ST_DONE;
				end
			end
			shl_pkg::ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = shl_pkg::ST_IDLE;
				end
			end
			default: state_d = shl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = 1'b0;
		ram_we    = 1'b0;
		rd_issue  = 1'b0;
		out_load  = 1'b0;
		clear     = 1'b0;
		case (state_q)
			shl_pkg::ST_IDLE: begin
				req.ready = 1'b1;
				ram_we    = req.valid && (rq.kind == shl_pkg::KIND_LOAD) &&
					(32'(rq.index) < MAX_HEADS);
				clear     = req.valid && is_query;
			end
			shl_pkg::ST_SCAN: begin
				rd_issue = (rd_cnt_q != n_q);
			end
			shl_pkg::ST_DONE: begin
				out_load = !out_valid_q || rsp.ready;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	assign wr_head = '{x: rq.pos_x, y: rq.pos_y, w: rq.size_w, h: rq.size_h};

	shl_ram #(
		.WIDTH($bits(shl_pkg::head_t)),
		.DEPTH(MAX_HEADS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(rq.index)),
		.wdata(wr_head),
		.raddr(rd_cnt_q[AW-1:0]),
		.rdata(rd_head)
	);

	shl_eval #(
		.NUM_W(NUM_W)
	) u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (clear),
		.valid_s1 (v_s1_q),
		.num_s1   (num_s1_q),
		.head_s1  (rd_head),
		.qx       (qx_q),
		.qy       (qy_q),
		.busy     (ev_busy),
		.found    (ev_found),
		.found_num(ev_found_num),
		.best_num (ev_best_num)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= shl_pkg::ST_IDLE;
			head_count_q <= '0;
			multi_q      <= 1'b0;
			n_q          <= '0;
			rd_cnt_q     <= '0;
			kind_q       <= shl_pkg::KIND_LOAD;
			v_s1_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				case (cfg.data.addr)
					shl_pkg::REG_HEAD_COUNT: head_count_q <= cfg.data.value;
					shl_pkg::REG_MULTI_HEAD: multi_q <= cfg.data.value[0];
					default: ;
				endcase
			end
			if (clear) begin
				n_q      <= n_d;
				rd_cnt_q <= '0;
				kind_q   <= rq.kind;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
			v_s1_q <= rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			qx_q <= qx_d;
			qy_q <= qy_d;
		end
		num_s1_q <= rd_cnt_q + 1'b1;
	end

	assign cfg.ready = 1'b1;

	always_comb begin
		if (ev_found) begin
			result = '{head_number: shl_pkg::HNUM_W'(ev_found_num), was_inside: 1'b1};
		end else if (kind_q == shl_pkg::KIND_WINDOW) begin
			result = '{head_number: shl_pkg::HNUM_W'(ev_best_num), was_inside: 1'b0};
		end else begin
			result = '{head_number: '0, was_inside: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= result;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == shl_pkg::ST_SCAN |-> rd_cnt_q <= n_q)
		else $error("read counter ran past the head count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shl_pkg::ST_SCAN && state_d == shl_pkg::ST_DONE) |-> (!v_s1_q && !ev_busy))
		else $error("scan finished with reads still in the pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1_q |-> $past(state_q) == shl_pkg::ST_SCAN)
		else $error("table read issued outside a scan");

	assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && is_query) |=> state_q == shl_pkg::ST_SCAN)
		else $error("query transfer did not start a scan");

endmodule
